>>> src/irhe_pkg.sv
// ----------------------------------------------------------------------------
// irhe_pkg
// Shared types and constants of the report-frame event decoder.
// ----------------------------------------------------------------------------
package irhe_pkg;

   localparam int MaxFrameBytes = 8;
   localparam int LaneCount     = 8;

   // configuration register indexes
   localparam logic [1:0] CSR_FIRST_BUTTON = 2'd0;
   localparam logic [1:0] CSR_BUTTON_COUNT = 2'd1;
   localparam logic [1:0] CSR_BYTE_ROLES   = 2'd2;

   // byte roles
   localparam logic [3:0] ROLE_BUTTONS    = 4'd1;
   localparam logic [3:0] ROLE_AXIS_FIRST = 4'd2;
   localparam logic [3:0] ROLE_AXIS_LAST  = 4'd12;

   // bounds of the axis id range that carries the raw byte
   localparam logic [3:0] AXIS_THROTTLE = 4'd7;
   localparam logic [3:0] AXIS_BRAKE    = 4'd9;

   // event kinds
   localparam logic [1:0] KIND_PRESS   = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_AXIS    = 2'd2;

   typedef struct packed {
      logic change;
      logic level;
   } lane_out_type;

   typedef struct packed {
      logic                       is_axis;
      logic [LaneCount-1:0]       mask;
      logic [LaneCount-1:0]       levels;
      logic [7:0]                 base_number;
      logic [3:0]                 axis_id;
      logic signed [8:0]          axis_value;
   } entry_type;

endpackage

>>> src/irhe_if.sv
// ----------------------------------------------------------------------------
// irhe_if
// Valid/ready channels for report bytes and decoded events.
// ----------------------------------------------------------------------------
interface irhe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic [2:0] byte_index;
   logic       frame_complete;

   modport source (output valid, output byte_value, output byte_index,
                   output frame_complete, input ready);
   modport sink   (input valid, input byte_value, input byte_index,
                   input frame_complete, output ready);
endinterface

interface irhe_rsp_if;
   logic              valid;
   logic              ready;
   logic [1:0]        event_kind;
   logic [6:0]        button_number;
   logic [3:0]        axis_id;
   logic signed [8:0] axis_value;
   logic              last_event;

   modport source (output valid, output event_kind, output button_number,
                   output axis_id, output axis_value, output last_event, input ready);
   modport sink   (input valid, input event_kind, input button_number,
                   input axis_id, input axis_value, input last_event, output ready);
endinterface

>>> src/input_report_to_hid_events_core.sv
// ----------------------------------------------------------------------------
// input_report_to_hid_events_core
// Turns report-frame bytes into button press/release and axis events.
// ----------------------------------------------------------------------------
// The button store is kept as words of eight buttons. When a byte is taken,
// the two words under the byte's buttons are read, eight bit lanes
// compare the byte with them and the words are written back at once, and the
// findings go to an event holder that feeds a registered output. The holder
// sends one event per cycle while the output is not stalled, so a button byte
// gives as many events as it has changed buttons (one to eight), an axis byte
// one, and a byte with no event none; the next byte is taken in the cycle its
// predecessor's last event leaves the holder. The button store resets to all
// released in the reset cycle.
module input_report_to_hid_events_core
   import irhe_pkg::*;
#(
   parameter int BUTTON_SLOTS = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   irhe_req_if.sink    req_if,
   irhe_rsp_if.source  rsp_if
);

   localparam int BankWords = BUTTON_SLOTS / 8;
   localparam int WordW     = $clog2(BankWords);

   logic [6:0]  first_button_ff, first_button_in;
   logic [6:0]  button_count_ff, button_count_in;
   logic [31:0] byte_roles_ff, byte_roles_in;
   logic [7:0]  button_bank_ff [BankWords];
   logic [7:0]  button_bank_in [BankWords];

   logic       accept;
   logic       merge_free;
   logic       item_ok;
   logic [3:0] role;
   logic       is_buttons;
   logic       is_axis;
   logic [3:0] axis_id;
   logic signed [8:0] axis_value;
   logic       load;
   entry_type  load_entry;

   logic [7:0]       base_number;
   logic [WordW-1:0] word_lo;
   logic [WordW-1:0] word_hi;
   logic [15:0]      window;
   logic [15:0]      window_next;
   logic [7:0]       lane_state;

   lane_out_type         lane_res  [LaneCount];
   logic [LaneCount-1:0] change_mask;

   assign req_if.ready = merge_free;
   assign accept       = req_if.valid && merge_free;
   assign item_ok      = req_if.frame_complete &&
                         ({1'b0, req_if.byte_index} < 4'(MaxFrameBytes));
   assign role         = 4'(byte_roles_ff >> {req_if.byte_index, 2'b00});
   assign is_buttons   = item_ok && (role == ROLE_BUTTONS);
   assign is_axis      = item_ok && (role >= ROLE_AXIS_FIRST) && (role <= ROLE_AXIS_LAST);
   assign axis_id      = role - ROLE_AXIS_FIRST;

   // (x*254)/255 equals x minus one for any nonzero byte
   always_comb begin
      if ((axis_id >= AXIS_THROTTLE) && (axis_id <= AXIS_BRAKE)) begin
         axis_value = $signed({1'b0, req_if.byte_value});
      end else begin
         axis_value = $signed({1'b0, req_if.byte_value}
                              - {8'd0, (req_if.byte_value != 8'd0)} - 9'd127);
      end
   end

   // the byte's buttons span at most two store words; lanes past the slot
   // limit are masked, so a wrapped upper word is never changed
   assign base_number = {1'b0, first_button_ff} + {2'b00, req_if.byte_index, 3'b000};
   assign word_lo     = base_number[WordW+2:3];
   assign word_hi     = word_lo + 1'b1;
   assign window      = {button_bank_ff[word_hi], button_bank_ff[word_lo]};
   assign lane_state  = 8'(window >> base_number[2:0]);
   assign window_next = window ^ ({8'd0, change_mask} << base_number[2:0]);

   for (genvar l = 0; l < LaneCount; l++) begin : g_lane
      irhe_button_lane #(
         .BUTTON_SLOTS (BUTTON_SLOTS),
         .LANE         (l)
      ) u_lane (
         .enable       (is_buttons),
         .bit_value    (req_if.byte_value[l]),
         .stored_level (lane_state[l]),
         .byte_index   (req_if.byte_index),
         .first_button (first_button_ff),
         .button_count (button_count_ff),
         .result       (lane_res[l])
      );
      assign change_mask[l]       = lane_res[l].change;
      assign load_entry.levels[l] = lane_res[l].level;
   end

   assign load_entry.is_axis     = is_axis;
   assign load_entry.mask        = change_mask;
   assign load_entry.base_number = base_number;
   assign load_entry.axis_id     = axis_id;
   assign load_entry.axis_value  = axis_value;

   // bytes with no event never enter the holder
   assign load = accept && (is_axis || (change_mask != '0));

   always_comb begin
      button_bank_in = button_bank_ff;
      if (accept) begin
         button_bank_in[word_lo] = window_next[7:0];
         button_bank_in[word_hi] = window_next[15:8];
      end
   end

   always_comb begin
      first_button_in = first_button_ff;
      button_count_in = button_count_ff;
      byte_roles_in   = byte_roles_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FIRST_BUTTON: first_button_in = csr_wdata[6:0];
            CSR_BUTTON_COUNT: button_count_in = csr_wdata[6:0];
            CSR_BYTE_ROLES:   byte_roles_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_button_ff <= '0;
         button_count_ff <= '0;
         byte_roles_ff   <= '0;
         for (int w = 0; w < BankWords; w++) begin
            button_bank_ff[w] <= '0;
         end
      end else begin
         first_button_ff <= first_button_in;
         button_count_ff <= button_count_in;
         byte_roles_ff   <= byte_roles_in;
         button_bank_ff  <= button_bank_in;
      end
   end

   irhe_event_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_entry (load_entry),
      .free       (merge_free),
      .rsp_if     (rsp_if)
   );

endmodule

>>> src/irhe_button_lane.sv
// ----------------------------------------------------------------------------
// irhe_button_lane
// One bit lane: maps a frame bit to its button and compares with the store.
// ----------------------------------------------------------------------------
module irhe_button_lane
   import irhe_pkg::*;
#(
   parameter int BUTTON_SLOTS = 128,
   parameter int LANE         = 0
) (
   input  logic         enable,
   input  logic         bit_value,
   input  logic         stored_level,
   input  logic [2:0]   byte_index,
   input  logic [6:0]   first_button,
   input  logic [6:0]   button_count,
   output lane_out_type result
);

   logic [5:0] pos;
   logic [7:0] num;
   logic       in_range;

   assign pos      = {byte_index, 3'(LANE)};
   assign num      = {1'b0, first_button} + {2'b00, pos};
   assign in_range = ({1'b0, pos} < button_count) && (num < 8'(BUTTON_SLOTS));

   assign result.level  = bit_value;
   assign result.change = enable && in_range && (stored_level != bit_value);

endmodule

>>> src/irhe_event_merge.sv
// ----------------------------------------------------------------------------
// irhe_event_merge
// Holds the lane findings of one byte and sends its events out one a cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module irhe_event_merge
   import irhe_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  entry_type load_entry,
   output logic      free,
   irhe_rsp_if.source rsp_if
);

   logic      entry_valid_ff, entry_valid_in;
   entry_type entry_ff, entry_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        kind_ff, kind_in;
   logic [6:0]        number_ff, number_in;
   logic [3:0]        axis_id_ff, axis_id_in;
   logic signed [8:0] axis_value_ff, axis_value_in;
   logic              last_ff, last_in;

   logic                 out_free;
   logic                 emit_go;
   logic                 emit_last;
   logic                 found;
   logic [2:0]           lane_sel;
   logic [LaneCount-1:0] remaining;
   logic [7:0]           number_wide;

   // lowest changed lane goes first
   always_comb begin
      found    = 1'b0;
      lane_sel = '0;
      for (int l = 0; l < LaneCount; l++) begin
         if (!found && entry_ff.mask[l]) begin
            found    = 1'b1;
            lane_sel = 3'(l);
         end
      end
   end

   assign remaining   = entry_ff.mask & ~(LaneCount'(1) << lane_sel);
   assign out_free    = !rsp_valid_ff || rsp_if.ready;
   assign emit_go     = entry_valid_ff && out_free;
   assign emit_last   = entry_ff.is_axis || (remaining == '0);
   assign free        = !entry_valid_ff || (emit_go && emit_last);
   assign number_wide = entry_ff.base_number + {5'b00000, lane_sel};

   always_comb begin
      entry_valid_in = entry_valid_ff;
      entry_in       = entry_ff;
      if (load) begin
         entry_valid_in = 1'b1;
         entry_in       = load_entry;
      end else if (emit_go && emit_last) begin
         entry_valid_in = 1'b0;
      end else if (emit_go) begin
         entry_in.mask = remaining;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      kind_in       = kind_ff;
      number_in     = number_ff;
      axis_id_in    = axis_id_ff;
      axis_value_in = axis_value_ff;
      last_in       = last_ff;
      if (emit_go) begin
         rsp_valid_in = 1'b1;
         last_in      = emit_last;
         if (entry_ff.is_axis) begin
            kind_in       = KIND_AXIS;
            number_in     = '0;
            axis_id_in    = entry_ff.axis_id;
            axis_value_in = entry_ff.axis_value;
         end else begin
            kind_in       = entry_ff.levels[lane_sel] ? KIND_PRESS : KIND_RELEASE;
            number_in     = number_wide[6:0];
            axis_id_in    = '0;
            axis_value_in = '0;
         end
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      entry_ff      <= entry_in;
      kind_ff       <= kind_in;
      number_ff     <= number_in;
      axis_id_ff    <= axis_id_in;
      axis_value_ff <= axis_value_in;
      last_ff       <= last_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.event_kind    = kind_ff;
   assign rsp_if.button_number = number_ff;
   assign rsp_if.axis_id       = axis_id_ff;
   assign rsp_if.axis_value    = axis_value_ff;
   assign rsp_if.last_event    = last_ff;

endmodule

>>> tb/input_report_to_hid_events_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// input_report_to_hid_events_core_tb
// Drives report-frame bytes through the decoder under several register
// settings and checks every button and axis event against a built-in model
// of the button store, the byte roles and the axis scaling.
// ----------------------------------------------------------------------------
module input_report_to_hid_events_core_tb;
   import irhe_pkg::*;

   localparam int BUTTON_SLOTS  = 128;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 12;
   localparam int QUIET_LIMIT   = 4000;
   localparam int RANDOM_PHASES = 6;
   localparam int PHASE_ITEMS   = 56;

   localparam logic [1:0] CSR_UNUSED   = 2'd3;
   localparam logic [3:0] ROLE_IGNORE  = 4'd0;
   localparam logic [3:0] ROLE_X       = 4'd2;
   localparam logic [3:0] ROLE_RUDDER  = 4'd8;
   localparam logic [3:0] ROLE_THROT   = 4'd9;
   localparam logic [3:0] ROLE_ACCEL   = 4'd10;
   localparam logic [3:0] ROLE_BRAKE   = 4'd11;
   localparam logic [3:0] ROLE_STEER   = 4'd12;
   localparam logic [3:0] ROLE_SPARE   = 4'd13;
   localparam logic [3:0] ROLE_SPARE_T = 4'd15;

   // idling styles
   localparam int IDLE_NONE = 0;
   localparam int IDLE_FULL = 1;
   localparam int IDLE_SOME = 2;

   typedef struct {
      logic [7:0] value;
      logic [2:0] index;
      logic       complete;
      int         idle_before;
      bit         after_drain;
   } report_byte_type;

   typedef struct {
      logic [1:0]        kind;
      logic [6:0]        number;
      logic [3:0]        axis;
      logic signed [8:0] value;
      logic              last_event;
   } hid_event_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   irhe_req_if req_ch ();
   irhe_rsp_if rsp_ch ();

   input_report_to_hid_events_core DUT (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch)
   );

   // model state
   logic [6:0]  cfg_first_button;
   logic [6:0]  cfg_button_count;
   logic [31:0] cfg_byte_roles;
   bit          button_down [BUTTON_SLOTS];

   report_byte_type report_bytes [$];
   hid_event_type   pending_events [$];
   report_byte_type launch;

   int error_count     = 0;
   int idle_count      = 0;
   int stall_left      = 0;
   int hold_left       = 0;
   int holds_requested = 0;
   int holds_served    = 0;
   int recv_mode       = IDLE_NONE;
   int recv_wait       = 0;
   int quiet_cycles    = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic int draw_wait(input int mode);
      if (mode == IDLE_FULL)
         return $urandom_range(0, 16);
      if (mode == IDLE_SOME && $urandom_range(0, 7) == 0)
         return $urandom_range(1, 16);
      return 0;
   endfunction

   // events caused by one accepted byte, in the order the block sends them
   function automatic void decode_report_byte(input logic [7:0] value, input logic [2:0] index,
                                              input logic complete);
      hid_event_type caused [$];
      hid_event_type ev;
      logic [3:0] role;
      int         idx;
      int         pos;
      int         number;
      int         scaled;
      if (!complete)
         return;
      idx  = index;
      role = cfg_byte_roles[4*idx +: 4];
      if (role == ROLE_BUTTONS) begin
         for (int b = 0; b < 8; b++) begin
            pos    = 8 * idx + b;
            number = int'(cfg_first_button) + pos;
            if (pos >= int'(cfg_button_count)) continue;
            if (number >= BUTTON_SLOTS) continue;
            if (button_down[number] == value[b]) continue;
            button_down[number] = value[b];
            ev.kind       = value[b] ? KIND_PRESS : KIND_RELEASE;
            ev.number     = number[6:0];
            ev.axis       = '0;
            ev.value      = '0;
            ev.last_event = 1'b0;
            caused.push_back(ev);
         end
      end else if (role >= ROLE_AXIS_FIRST && role <= ROLE_AXIS_LAST) begin
         ev.kind   = KIND_AXIS;
         ev.number = '0;
         ev.axis   = role - ROLE_AXIS_FIRST;
         // pedals pass the raw byte, the rest are centered
         if (ev.axis >= AXIS_THROTTLE && ev.axis <= AXIS_BRAKE)
            scaled = int'(value);
         else
            scaled = (int'(value) * 254) / 255 - 127;
         ev.value      = scaled[8:0];
         ev.last_event = 1'b0;
         caused.push_back(ev);
      end
      if (caused.size() > 0)
         caused[caused.size()-1].last_event = 1'b1;
      foreach (caused[i])
         pending_events.push_back(caused[i]);
   endfunction

   task automatic check_event();
      hid_event_type want;
      if (pending_events.size() == 0) begin
         $error("unexpected event: kind %0d button %0d axis %0d value %0d",
                rsp_ch.event_kind, rsp_ch.button_number, rsp_ch.axis_id, rsp_ch.axis_value);
         error_count++;
         return;
      end
      want = pending_events.pop_front();
      if (rsp_ch.event_kind !== want.kind) begin
         $error("event_kind mismatch: expected %0d, actual %0d", want.kind, rsp_ch.event_kind);
         error_count++;
      end
      if (rsp_ch.button_number !== want.number) begin
         $error("button_number mismatch: expected %0d, actual %0d",
                want.number, rsp_ch.button_number);
         error_count++;
      end
      if (rsp_ch.axis_id !== want.axis) begin
         $error("axis_id mismatch: expected %0d, actual %0d", want.axis, rsp_ch.axis_id);
         error_count++;
      end
      if (rsp_ch.axis_value !== want.value) begin
         $error("axis_value mismatch: expected %0d, actual %0d", want.value, rsp_ch.axis_value);
         error_count++;
      end
      if (rsp_ch.last_event !== want.last_event) begin
         $error("last_event mismatch: expected %0d, actual %0d",
                want.last_event, rsp_ch.last_event);
         error_count++;
      end
   endtask

   // byte driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         idle_count   <= 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            decode_report_byte(req_ch.byte_value, req_ch.byte_index, req_ch.frame_complete);
         if (!req_ch.valid || req_ch.ready) begin
            if (report_bytes.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (idle_count < report_bytes[0].idle_before ||
                         (report_bytes[0].after_drain && pending_events.size() != 0)) begin
               req_ch.valid <= 1'b0;
               idle_count   <= idle_count + 1;
            end else begin
               launch = report_bytes.pop_front();
               req_ch.valid          <= 1'b1;
               req_ch.byte_value     <= launch.value;
               req_ch.byte_index     <= launch.index;
               req_ch.frame_complete <= launch.complete;
               idle_count            <= 0;
            end
         end
      end
   end

   // event monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= 0;
         hold_left    <= 0;
         holds_served <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready)
            check_event();
         if (holds_served != holds_requested) begin
            holds_served <= holds_requested;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
         end else if (rsp_ch.valid && rsp_ch.ready) begin
            recv_wait     = draw_wait(recv_mode);
            stall_left   <= recv_wait;
            rsp_ch.ready <= (recv_wait == 0);
         end else if (stall_left > 0) begin
            stall_left   <= stall_left - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic void add_item(input logic [7:0] value, input logic [2:0] index,
                                    input logic complete, input int idle,
                                    input bit after_drain);
      report_byte_type item;
      item.value       = value;
      item.index       = index;
      item.complete    = complete;
      item.idle_before = idle;
      item.after_drain = after_drain;
      report_bytes.push_back(item);
   endfunction

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         CSR_FIRST_BUTTON: cfg_first_button = data[6:0];
         CSR_BUTTON_COUNT: cfg_button_count = data[6:0];
         CSR_BYTE_ROLES:   cfg_byte_roles   = data;
         default: ;
      endcase
   endtask

   // upper bits of the narrow registers carry noise that must be dropped
   task automatic configure(input int first, input int count, input logic [31:0] roles);
      write_csr(CSR_FIRST_BUTTON, ($urandom() & ~32'h7f) | first);
      write_csr(CSR_BUTTON_COUNT, ($urandom() & ~32'h7f) | count);
      write_csr(CSR_BYTE_ROLES, roles);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (report_bytes.size() != 0 || req_ch.valid || pending_events.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function automatic logic [3:0] random_role();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 4)
         return ROLE_BUTTONS;
      if (roll < 9)
         return 4'($urandom_range(ROLE_AXIS_FIRST, ROLE_AXIS_LAST));
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic logic [7:0] random_value();
      if ($urandom_range(0, 5) == 0)
         return $urandom_range(0, 1) ? 8'hff : 8'h00;
      return 8'($urandom());
   endfunction

   initial begin
      logic [31:0] roles;
      int          first;
      int          count;
      int          send_mode;
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_ch.valid          = 1'b0;
      req_ch.byte_value     = '0;
      req_ch.byte_index     = '0;
      req_ch.frame_complete = 1'b0;
      rsp_ch.ready          = 1'b0;
      cfg_first_button      = '0;
      cfg_button_count      = '0;
      cfg_byte_roles        = '0;
      foreach (button_down[i]) button_down[i] = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: every position ignored
      add_item(8'hff, 3'd0, 1'b1, 0, 1'b0);
      wait_until_idle();

      // buttons on the low four positions, three axis positions above
      configure(0, 64, {ROLE_SPARE_T, ROLE_STEER, ROLE_THROT, ROLE_X,
                        ROLE_BUTTONS, ROLE_BUTTONS, ROLE_BUTTONS, ROLE_BUTTONS});
      write_csr(CSR_UNUSED, 32'hffff_ffff);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      recv_mode = IDLE_SOME;
      add_item(8'hff, 3'd0, 1'b1, 0, 1'b0);
      add_item(8'h00, 3'd0, 1'b1, 0, 1'b0);
      add_item(8'h00, 3'd0, 1'b1, 2, 1'b0);   // nothing changed
      add_item(8'ha5, 3'd1, 1'b1, 0, 1'b0);
      add_item(8'hff, 3'd0, 1'b0, 0, 1'b0);   // incomplete frame
      add_item(8'h00, 3'd4, 1'b1, 0, 1'b0);
      add_item(8'hff, 3'd4, 1'b1, 5, 1'b0);
      add_item(8'h00, 3'd5, 1'b1, 0, 1'b0);
      add_item(8'hff, 3'd5, 1'b1, 0, 1'b0);
      add_item(8'h7f, 3'd6, 1'b1, 0, 1'b0);
      add_item(8'hff, 3'd7, 1'b1, 0, 1'b0);   // unused role
      add_item(8'hff, 3'd3, 1'b1, 0, 1'b0);
      add_item(8'h00, 3'd3, 1'b1, 0, 1'b0);
      wait_until_idle();

      // short button range starting high
      configure(100, 12, {ROLE_BUTTONS, ROLE_RUDDER, ROLE_SPARE, ROLE_IGNORE,
                          ROLE_ACCEL, ROLE_BRAKE, ROLE_BUTTONS, ROLE_BUTTONS});
      add_item(8'hff, 3'd0, 1'b1, 0, 1'b0);
      add_item(8'hff, 3'd1, 1'b1, 0, 1'b0);
      add_item(8'hff, 3'd7, 1'b1, 0, 1'b0);   // past the button count
      add_item(8'h00, 3'd0, 1'b1, 0, 1'b0);
      add_item(8'h55, 3'd2, 1'b1, 0, 1'b0);
      add_item(8'haa, 3'd3, 1'b1, 0, 1'b0);
      add_item(8'h3c, 3'd6, 1'b1, 0, 1'b0);
      add_item(8'h11, 3'd5, 1'b1, 0, 1'b0);
      wait_until_idle();

      // only bit zero maps below the slot limit
      configure(127, 64, 32'h1111_1111);
      add_item(8'hff, 3'd0, 1'b1, 0, 1'b0);
      add_item(8'hfe, 3'd1, 1'b1, 0, 1'b0);
      wait_until_idle();

      configure(0, 0, 32'hffff_fff1);
      add_item(8'hff, 3'd0, 1'b1, 0, 1'b0);
      add_item(8'hff, 3'd1, 1'b1, 0, 1'b0);
      wait_until_idle();

      for (int k = 0; k < RANDOM_PHASES; k++) begin
         case (k)
            0:       first = 0;
            1:       first = 127;
            2:       first = 64;
            default: first = $urandom_range(0, 127);
         endcase
         count = (k % 2 == 0) ? 64 : $urandom_range(0, 64);
         if (k == 1) count = 64;
         for (int p = 0; p < 8; p++)
            roles[4*p +: 4] = random_role();
         configure(first, count, roles);
         send_mode = k % 3;
         recv_mode = (k + 1) % 3;
         // long receiver hold-off against a sender that never pauses
         if (k == 1) begin
            send_mode = IDLE_NONE;
            holds_requested++;
         end
         for (int n = 0; n < PHASE_ITEMS; n++)
            add_item(random_value(), 3'($urandom_range(0, 7)), $urandom_range(0, 7) != 0,
                     draw_wait(send_mode), n == PHASE_ITEMS / 2);
         wait_until_idle();
      end

      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
